[hw/rtl/sfs_pkg.sv]
`timescale 1ns / 1ps
// sfs_pkg: shared types, register indexes and constants of the sprite frame sequencer
// used by every module of the block but sfs_checker; depends on nothing

package sfs_pkg;

  localparam int FRAME_COUNT = 256;
  localparam int CLIP_DEPTH  = 64;
  localparam int CLIP_AW     = 6;
  localparam int MAX_ADVANCE = 16;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CW      = $clog2(DIV_STEPS);
  localparam int PADDR_W     = 5;

  localparam logic [2:0] REG_PLAY_MODE      = 3'd0;
  localparam logic [2:0] REG_START_FRAME    = 3'd1;
  localparam logic [2:0] REG_END_FRAME      = 3'd2;
  localparam logic [2:0] REG_FRAME_DURATION = 3'd3;
  localparam logic [2:0] REG_SPEED          = 3'd4;
  localparam logic [2:0] REG_COLUMNS        = 3'd5;
  localparam logic [2:0] REG_ROWS           = 3'd6;
  localparam logic [2:0] REG_CLIP_LENGTH    = 3'd7;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic [1:0]  play_mode;
    logic [7:0]  start_frame;
    logic [7:0]  end_frame;
    logic [23:0] frame_duration;
    logic [15:0] speed;
    logic [8:0]  columns;
    logic [8:0]  rows;
    logic [6:0]  clip_length;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic accum;
    logic restart;
    logic adv;
    logic fetch;
    logic div_step;
    logic emit;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic acc_ge_dur;
    logic fin;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/sfs_cfg_regs.sv]
`timescale 1ns / 1ps
// sfs_cfg_regs: apb register file of the sprite frame sequencer
// raises a restart pulse the cycle after every write; depends on sfs_pkg

module sfs_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output sfs_pkg::cfg_t               cfg_o,
  output logic                        restart_o
);

  sfs_pkg::cfg_t cfg_q;
  logic          restart_q;
  logic          wr;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.play_mode      <= 2'd1;
      cfg_q.start_frame    <= 8'd0;
      cfg_q.end_frame      <= 8'd0;
      cfg_q.frame_duration <= 24'd1;
      cfg_q.speed          <= 16'd256;
      cfg_q.columns        <= 9'd1;
      cfg_q.rows           <= 9'd1;
      cfg_q.clip_length    <= 7'd1;
      restart_q            <= 1'b0;
    end else begin
      restart_q <= wr;
      if (wr) begin
        case (idx)
          sfs_pkg::REG_PLAY_MODE:      cfg_q.play_mode      <= pwdata[1:0];
          sfs_pkg::REG_START_FRAME:    cfg_q.start_frame    <= pwdata[7:0];
          sfs_pkg::REG_END_FRAME:      cfg_q.end_frame      <= pwdata[7:0];
          sfs_pkg::REG_FRAME_DURATION: cfg_q.frame_duration <= pwdata[23:0];
          sfs_pkg::REG_SPEED:          cfg_q.speed          <= pwdata[15:0];
          sfs_pkg::REG_COLUMNS:        cfg_q.columns        <= pwdata[8:0];
          sfs_pkg::REG_ROWS:           cfg_q.rows           <= pwdata[8:0];
          sfs_pkg::REG_CLIP_LENGTH:    cfg_q.clip_length    <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      sfs_pkg::REG_PLAY_MODE:      prdata = {30'd0, cfg_q.play_mode};
      sfs_pkg::REG_START_FRAME:    prdata = {24'd0, cfg_q.start_frame};
      sfs_pkg::REG_END_FRAME:      prdata = {24'd0, cfg_q.end_frame};
      sfs_pkg::REG_FRAME_DURATION: prdata = {8'd0, cfg_q.frame_duration};
      sfs_pkg::REG_SPEED:          prdata = {16'd0, cfg_q.speed};
      sfs_pkg::REG_COLUMNS:        prdata = {23'd0, cfg_q.columns};
      sfs_pkg::REG_ROWS:           prdata = {23'd0, cfg_q.rows};
      sfs_pkg::REG_CLIP_LENGTH:    prdata = {25'd0, cfg_q.clip_length};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg_o     = cfg_q;
  assign restart_o = restart_q;

endmodule

[hw/rtl/sfs_ctrl.sv]
`timescale 1ns / 1ps
// sfs_ctrl: state machine that sequences accumulate, advance, divide and emit
// drives the datapath through sfs_pkg::cmd_t; depends on sfs_pkg

module sfs_ctrl #(
  parameter int MAX_ADVANCE = sfs_pkg::MAX_ADVANCE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          func_i,
  output logic          in_stall_o,
  input  logic          restart_i,
  input  sfs_pkg::sts_t sts_i,
  output sfs_pkg::cmd_t cmd_o
);

  localparam int CW = $clog2(MAX_ADVANCE + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_ADV,
    ST_FETCH,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                     state_q;
  logic [CW-1:0]              cnt_q;
  logic [sfs_pkg::DIV_CW-1:0] div_cnt_q;
  logic                       accept;
  logic                       cnt_full;

  assign in_stall_o = (state_q != ST_IDLE) | restart_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cnt_full   = (cnt_q == CW'(MAX_ADVANCE));

  always_comb begin
    cmd_o          = '0;
    cmd_o.restart  = restart_i;
    cmd_o.load     = accept & (func_i == sfs_pkg::FUNC_LOAD);
    cmd_o.mul      = accept & (func_i == sfs_pkg::FUNC_TICK) & ~sts_i.done;
    cmd_o.accum    = (state_q == ST_ACCUM);
    cmd_o.adv      = (state_q == ST_ADV);
    cmd_o.fetch    = (state_q == ST_FETCH);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.emit     = (state_q == ST_EMIT) & sts_i.out_free;
    cmd_o.last     = sts_i.fin | cnt_full | ~sts_i.acc_ge_dur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.mul) begin
            cnt_q   <= '0;
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          state_q <= sts_i.acc_ge_dur ? ST_ADV : ST_IDLE;
        end
        ST_ADV: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= ST_FETCH;
        end
        ST_FETCH: begin
          div_cnt_q <= '0;
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + sfs_pkg::DIV_CW'(1);
          if (div_cnt_q == sfs_pkg::DIV_CW'(sfs_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sts_i.out_free) begin
            state_q <= cmd_o.last ? ST_IDLE : ST_ADV;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/sfs_datapath.sv]
`timescale 1ns / 1ps
// sfs_datapath: accumulator, frame stepping, clip table, serial divider and output register
// acts on sfs_pkg::cmd_t from sfs_ctrl; depends on sfs_pkg

module sfs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sfs_pkg::cfg_t               cfg_i,
  input  sfs_pkg::cmd_t               cmd_i,
  output sfs_pkg::sts_t               sts_o,
  input  logic [15:0]                 dt_i,
  input  logic [sfs_pkg::CLIP_AW-1:0] entry_index_i,
  input  logic [7:0]                  entry_frame_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  frame_o,
  output logic [5:0]                  clip_position_o,
  output logic [7:0]                  column_o,
  output logic [7:0]                  flipped_row_o,
  output logic                        finished_o,
  output logic                        last_o
);

  logic [7:0]  clip_mem_q [sfs_pkg::CLIP_DEPTH];
  logic [7:0]  rd_q;

  logic [31:0] acc_q;
  logic [31:0] prod_q;
  logic [7:0]  frame_q;
  logic [sfs_pkg::CLIP_AW-1:0] pos_q;
  logic        done_q;
  logic        fin_q;
  logic [8:0]  rem_q;
  logic [7:0]  quo_q;
  logic        out_valid_q;

  logic        loop_en;
  logic        clip_mode;
  logic [15:0] sp_eff;
  logic [23:0] fd_eff;
  logic [31:0] dur;
  logic [8:0]  col_eff;
  logic [8:0]  row_eff;
  logic [6:0]  len_eff;
  logic [32:0] sum;
  logic [6:0]  pos_inc;
  logic [6:0]  pos_next;
  logic        pos_fin;
  logic [8:0]  frm_inc;
  logic [7:0]  frm_next;
  logic        frm_fin;
  logic [9:0]  div_t;
  logic        div_ge;
  logic [9:0]  row_p1;
  logic [9:0]  fr_full;
  logic [7:0]  fr_sat;

  assign loop_en   = cfg_i.play_mode[0];
  assign clip_mode = cfg_i.play_mode[1];
  assign sp_eff    = (cfg_i.speed == '0) ? 16'd1 : cfg_i.speed;
  assign fd_eff    = (cfg_i.frame_duration == '0) ? 24'd1 : cfg_i.frame_duration;
  assign dur       = {fd_eff, 8'd0};
  assign col_eff   = (cfg_i.columns == '0) ? 9'd1 : cfg_i.columns;
  assign row_eff   = (cfg_i.rows == '0) ? 9'd1 : cfg_i.rows;

  always_comb begin
    if (cfg_i.clip_length == '0) begin
      len_eff = 7'd1;
    end else if (cfg_i.clip_length > 7'(sfs_pkg::CLIP_DEPTH)) begin
      len_eff = 7'(sfs_pkg::CLIP_DEPTH);
    end else begin
      len_eff = cfg_i.clip_length;
    end
  end

  assign sum = {1'b0, acc_q} + {1'b0, prod_q};

  // clip position step
  assign pos_inc = {1'b0, pos_q} + 7'd1;
  always_comb begin
    pos_next = pos_inc;
    pos_fin  = 1'b0;
    if (pos_inc >= len_eff) begin
      if (loop_en) begin
        pos_next = 7'd0;
      end else begin
        pos_next = len_eff - 7'd1;
        pos_fin  = 1'b1;
      end
    end
  end

  // range frame step
  assign frm_inc = {1'b0, frame_q} + 9'd1;
  always_comb begin
    frm_next = frm_inc[7:0];
    frm_fin  = 1'b0;
    if ((frm_inc > {1'b0, cfg_i.end_frame}) ||
        (32'(frm_inc) >= 32'(sfs_pkg::FRAME_COUNT))) begin
      if (loop_en) begin
        frm_next = cfg_i.start_frame;
      end else begin
        frm_next = cfg_i.end_frame;
        frm_fin  = 1'b1;
      end
    end
  end

  // one restoring division step
  assign div_t  = {rem_q, quo_q[7]};
  assign div_ge = (div_t >= {1'b0, col_eff});

  // flipped row from the quotient
  assign row_p1  = {2'd0, quo_q} + 10'd1;
  assign fr_full = {1'b0, row_eff} - row_p1;
  always_comb begin
    if (row_p1 > {1'b0, row_eff}) begin
      fr_sat = 8'd0;
    end else if (fr_full > 10'd255) begin
      fr_sat = 8'd255;
    end else begin
      fr_sat = fr_full[7:0];
    end
  end

  // clip table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      clip_mem_q[entry_index_i] <= entry_frame_i;
    end
    rd_q <= clip_mem_q[pos_next[sfs_pkg::CLIP_AW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 32'(dt_i) * 32'(sp_eff);
    end
    if (cmd_i.fetch) begin
      quo_q <= clip_mode ? rd_q : frame_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? 9'(div_t - {1'b0, col_eff}) : div_t[8:0];
      quo_q <= {quo_q[6:0], div_ge};
    end
    if (cmd_i.emit) begin
      frame_o         <= frame_q;
      clip_position_o <= clip_mode ? 6'(pos_q) : 6'd0;
      column_o        <= rem_q[7:0];
      flipped_row_o   <= fr_sat;
      finished_o      <= fin_q;
      last_o          <= cmd_i.last;
    end
  end

  // playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      frame_q     <= '0;
      pos_q       <= '0;
      done_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        acc_q   <= '0;
        pos_q   <= '0;
        done_q  <= 1'b0;
        frame_q <= cfg_i.start_frame;
      end else begin
        if (cmd_i.accum) begin
          acc_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (cmd_i.adv) begin
          acc_q <= acc_q - dur;
          if (clip_mode) begin
            pos_q <= pos_next[sfs_pkg::CLIP_AW-1:0];
            fin_q <= pos_fin;
          end else begin
            frame_q <= frm_next;
            fin_q   <= frm_fin;
          end
        end
        if (cmd_i.fetch && clip_mode) begin
          frame_q <= rd_q;
        end
        if (cmd_i.emit && fin_q) begin
          done_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.done       = done_q;
  assign sts_o.acc_ge_dur = (acc_q >= dur);
  assign sts_o.fin        = fin_q;
  assign sts_o.out_free   = ~out_valid_q | ~out_stall_i;

endmodule

[hw/rtl/sprite_frame_sequencer_top.sv]
`timescale 1ns / 1ps
// sprite_frame_sequencer_top: top level of the sprite frame sequencer
// ties together sfs_cfg_regs, sfs_ctrl and sfs_datapath; depends on sfs_pkg

// A tick multiplies dt by speed, accumulates, and checks the accumulator against the frame
// duration, then makes a frame advance while it still holds (up to MAX_ADVANCE advances); each
// advance steps the frame, reads the clip table, runs the 8-step serial divider that splits
// the frame into sheet column and row, and loads the output register, waiting while it is stalled.
// A tick after playback has finished is taken with no result. Every register
// write restarts playback and holds off input requests for the following cycle.

module sprite_frame_sequencer_top #(
  parameter int MAX_ADVANCE = sfs_pkg::MAX_ADVANCE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [15:0]                 dt_i,
  input  logic [5:0]                  entry_index_i,
  input  logic [7:0]                  entry_frame_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  frame_o,
  output logic [5:0]                  clip_position_o,
  output logic [7:0]                  column_o,
  output logic [7:0]                  flipped_row_o,
  output logic                        finished_o,
  output logic                        last_o
);

  sfs_pkg::cfg_t cfg;
  sfs_pkg::cmd_t cmd;
  sfs_pkg::sts_t sts;
  logic          restart;

  sfs_cfg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  sfs_ctrl #(
    .MAX_ADVANCE (MAX_ADVANCE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfs_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .dt_i            (dt_i),
    .entry_index_i   (entry_index_i),
    .entry_frame_i   (entry_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_o         (frame_o),
    .clip_position_o (clip_position_o),
    .column_o        (column_o),
    .flipped_row_o   (flipped_row_o),
    .finished_o      (finished_o),
    .last_o          (last_o)
  );

endmodule

[hw/rtl/sfs_checker.sv]
`timescale 1ns / 1ps
// sfs_checker: port-level assertions for the sprite frame sequencer
// bound to sprite_frame_sequencer_top at the end of this file; no package use

module sfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic pready,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic finished_o,
  input logic last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a register write holds off the next input request
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=> in_stall_o)
    else $error("input taken during restart");

  // a stalled input request stays offered
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("input request withdrawn while stalled");

  // the finishing result always ends its tick
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> last_o)
    else $error("finished result not marked last");

endmodule

bind sprite_frame_sequencer_top sfs_checker u_sfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pready      (pready),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .finished_o  (finished_o),
  .last_o      (last_o)
);
